// ----- rtl/key_velocity_tracker_defines.svh -----
// Assertion macros shared by the key velocity tracker modules.
`ifndef KEY_VELOCITY_TRACKER_DEFINES_SVH
`define KEY_VELOCITY_TRACKER_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define KVT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kvt_pkg.sv -----
// Types, constants and register codes of the key velocity tracker.
`timescale 1ns / 1ps
package kvt_pkg;

  localparam int KEY_COUNT = 128;
  localparam int IDX_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  localparam int KEY_W   = 7;
  localparam int LEVEL_W = 16;
  localparam int STAMP_W = 32;
  localparam int VEL_W   = 7;
  localparam int NOTE_W  = 7;
  localparam int DATA_W  = 16;
  localparam int ADDR_W  = 2;

  // Divider sizes: numerator is dv * 100, divisor is dt shifted to the top quotient bit
  localparam int NUM_W = LEVEL_W + 7;
  localparam int DEN_W = STAMP_W + VEL_W;
  localparam int CNT_W = 3;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(VEL_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [ADDR_W-1:0] REG_TH_LOW     = 2'd0;
  localparam logic [ADDR_W-1:0] REG_TH_HIGH    = 2'd1;
  localparam logic [ADDR_W-1:0] REG_TH_RELEASE = 2'd2;
  localparam logic [ADDR_W-1:0] REG_BASE_NOTE  = 2'd3;

  localparam logic [LEVEL_W-1:0] TH_LOW_RESET     = 16'd1000;
  localparam logic [LEVEL_W-1:0] TH_HIGH_RESET    = 16'd3000;
  localparam logic [LEVEL_W-1:0] TH_RELEASE_RESET = 16'd800;
  localparam logic [NOTE_W-1:0]  BASE_NOTE_RESET  = 7'd0;

  // Key modes; code 3 never arises and acts as idle
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_TRACKING = 2'd1;
  localparam logic [1:0] MODE_HELD     = 2'd2;

  // Event kinds
  localparam logic EV_NOTE_ON  = 1'b0;
  localparam logic EV_NOTE_OFF = 1'b1;

  localparam logic [VEL_W-1:0] VEL_SCALE   = 7'd100;
  localparam logic [VEL_W-1:0] VEL_MIN     = 7'd1;
  localparam logic [VEL_W-1:0] VEL_MAX     = 7'd127;
  localparam logic [VEL_W-1:0] VEL_DEFAULT = 7'd64;

  typedef struct packed {
    logic [LEVEL_W-1:0] th_low;
    logic [LEVEL_W-1:0] th_high;
    logic [LEVEL_W-1:0] th_release;
    logic [NOTE_W-1:0]  base_note;
  } kvt_cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [LEVEL_W-1:0] level;
    logic [STAMP_W-1:0] stamp;
  } kvt_item_t;

  // Per-key record held in the key RAM
  typedef struct packed {
    logic [1:0]         mode;
    logic [LEVEL_W-1:0] level;
    logic [STAMP_W-1:0] stamp;
    logic [VEL_W-1:0]   vel;
    logic               snd;
  } kvt_rec_t;

  localparam int REC_W = $bits(kvt_rec_t);

endpackage

// ----- rtl/kvt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/kvt_front.sv -----
// Front end: accepts sample words, drops out-of-range keys, queues the rest.
`timescale 1ns / 1ps
`include "key_velocity_tracker_defines.svh"
module kvt_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [kvt_pkg::KEY_W-1:0]   key_number_i,
  input  logic [kvt_pkg::LEVEL_W-1:0] sample_value_i,
  input  logic [kvt_pkg::STAMP_W-1:0] time_us_i,
  output logic                      item_valid_o,
  output kvt_pkg::kvt_item_t        item_o,
  input  logic                      pop_i
);
  import kvt_pkg::*;

  kvt_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              accept;
  logic              push;

  // Classify: keys beyond the key count are taken and dropped
  assign in_stall_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && (int'(key_number_i) < KEY_COUNT);

  // Advance pointers and fill count
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store the queued word
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= '{key: key_number_i, level: sample_value_i, stamp: time_us_i};
    end
  end

  assign item_valid_o = (count_q != '0);
  assign item_o       = slot_q[rptr_q];

  `KVT_ASSERT_IMPL(a_pop_nonempty, pop_i, count_q != '0, "kvt_front: pop from empty queue")

endmodule

// ----- rtl/kvt_back.sv -----
// Back end: per-key tracker, velocity divider and output register.
`timescale 1ns / 1ps
`include "key_velocity_tracker_defines.svh"
module kvt_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kvt_pkg::kvt_cfg_t         cfg_i,
  input  logic                      item_valid_i,
  input  kvt_pkg::kvt_item_t        item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      event_kind_o,
  output logic [kvt_pkg::NOTE_W-1:0] note_number_o,
  output logic [kvt_pkg::VEL_W-1:0]  note_velocity_o,
  output logic [kvt_pkg::KEY_W-1:0]  event_key_o
);
  import kvt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } kvt_state_e;

  kvt_state_e         state_q, state_d;
  kvt_item_t          item_q;
  logic               vbit_q;
  logic [KEY_COUNT-1:0] kvalid_q;
  kvt_rec_t           ram_rdata;
  kvt_rec_t           cur;
  kvt_rec_t           rec_q, rec_d;
  logic               ev_q, ev_d;
  logic               kind_q, kind_d;
  logic [NUM_W-1:0]   rem_q, rem_d;
  logic [DEN_W-1:0]   den_q, den_d;
  logic [VEL_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   raddr;
  logic [IDX_W-1:0]   waddr;
  logic [LEVEL_W-1:0] dv;
  logic [STAMP_W-1:0] dt;
  logic               ge;
  logic               out_free;
  logic               out_load;
  logic               ram_we;
  logic               out_valid_q;
  logic               out_kind_q;
  logic [NOTE_W-1:0]  out_note_q;
  logic [VEL_W-1:0]   out_vel_q;
  logic [KEY_W-1:0]   out_key_q;

  assign pop_o    = item_valid_i && (state_q == S_IDLE);
  assign raddr    = IDX_W'(item_i.key);
  assign waddr    = IDX_W'(item_q.key);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_FIN) && ev_q && out_free;
  assign ram_we   = (state_q == S_FIN) && (!ev_q || out_free);

  kvt_ram #(
    .WIDTH (REC_W),
    .DEPTH (KEY_COUNT)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (rec_q),
    .re_i    (pop_o),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // A key never written reads as its reset record: idle, all zero
  assign cur = vbit_q ? ram_rdata : '0;
  assign dv  = item_q.level - cur.level;
  assign dt  = item_q.stamp - cur.stamp;
  assign ge  = {{(DEN_W - NUM_W){1'b0}}, rem_q} >= den_q;

  // Sequence one sample: look up, decide, divide, write back
  always_comb begin
    state_d = state_q;
    rec_d   = rec_q;
    ev_d    = ev_q;
    kind_d  = kind_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        rec_d   = cur;
        ev_d    = 1'b0;
        kind_d  = EV_NOTE_ON;
        state_d = S_FIN;
        unique case (cur.mode)
          MODE_TRACKING: begin
            if (item_q.level > cfg_i.th_high) begin
              rec_d.mode = MODE_HELD;
              rec_d.snd  = 1'b1;
              ev_d       = 1'b1;
              kind_d     = EV_NOTE_ON;
              if (dt == '0) begin
                rec_d.vel = VEL_DEFAULT;
              end else begin
                rem_d   = NUM_W'(dv) * NUM_W'(VEL_SCALE);
                den_d   = {dt, {VEL_W{1'b0}}};
                quo_d   = '0;
                cnt_d   = DIV_LAST;
                state_d = S_DIV;
              end
            end else if (item_q.level < cfg_i.th_low) begin
              rec_d.mode = MODE_IDLE;
            end
          end
          MODE_HELD: begin
            if (item_q.level < cfg_i.th_release) begin
              rec_d.mode = MODE_IDLE;
              if (cur.snd) begin
                rec_d.snd = 1'b0;
                ev_d      = 1'b1;
                kind_d    = EV_NOTE_OFF;
              end
            end
          end
          default: begin
            if (item_q.level > cfg_i.th_low) begin
              rec_d.mode  = MODE_TRACKING;
              rec_d.level = item_q.level;
              rec_d.stamp = item_q.stamp;
            end
          end
        endcase
      end
      S_DIV: begin
        // One quotient bit per cycle; the top bit set means saturate
        if (ge) begin
          rem_d = rem_q - den_q[NUM_W-1:0];
        end
        quo_d = {quo_q[VEL_W-2:0], ge};
        den_d = den_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if ((cnt_q == DIV_LAST) && ge) begin
          rec_d.vel = VEL_MAX;
          state_d   = S_FIN;
        end else if (cnt_q == '0) begin
          rec_d.vel = (quo_d == '0) ? VEL_MIN : quo_d;
          state_d   = S_FIN;
        end
      end
      S_FIN: begin
        // Hold here while an event waits on an occupied, stalled output register
        if (ram_we) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kvalid_q <= '0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        kvalid_q[waddr] <= 1'b1;
      end
    end
  end

  // Working registers of the current sample
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
      vbit_q <= kvalid_q[raddr];
    end
    rec_q  <= rec_d;
    ev_q   <= ev_d;
    kind_q <= kind_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= kind_q;
      out_note_q <= NOTE_W'(cfg_i.base_note + NOTE_W'(item_q.key));
      out_vel_q  <= rec_q.vel;
      out_key_q  <= item_q.key;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = out_kind_q;
  assign note_number_o   = out_note_q;
  assign note_velocity_o = out_vel_q;
  assign event_key_o     = out_key_q;

  `KVT_ASSERT_IMPL(a_no_overwrite, out_load && out_valid_q, !out_stall_i, "kvt_back: result overwritten")
  `KVT_ASSERT_IMPL(a_on_velocity, out_valid_q && (out_kind_q == EV_NOTE_ON), out_vel_q != '0, "kvt_back: note-on velocity zero")
  `KVT_ASSERT_NEXT(a_pop_look, pop_o, state_q == S_LOOK, "kvt_back: lookup skipped after pop")

endmodule

// ----- rtl/key_velocity_tracker.sv -----
// Top level of the key velocity tracker: configuration registers, front and back ends.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o   key_number, sample_value, time_us
//   out      output     out_valid_o/out_stall_i event_kind, note_number, note_velocity,
//                                               event_key
//   cfg      input      cfg_we_i                cfg_addr_i, cfg_wdata_i
//
// In the back end a sample passes queue pop, key RAM read and write back.
// A note-on with nonzero elapsed time adds the restoring divider before write back; it
// stops at the first quotient bit when the velocity saturates.
// The front queue holds two samples, so the input stalls only when both are waiting.
// Reset clears per-key valid bits at once; no clearing pass, the key RAM is not swept.
// While the output register is held by out_stall_i, a pending event waits at write back.
`timescale 1ns / 1ps
module key_velocity_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kvt_pkg::ADDR_W-1:0]  cfg_addr_i,
  input  logic [kvt_pkg::DATA_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kvt_pkg::KEY_W-1:0]   key_number_i,
  input  logic [kvt_pkg::LEVEL_W-1:0] sample_value_i,
  input  logic [kvt_pkg::STAMP_W-1:0] time_us_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        event_kind_o,
  output logic [kvt_pkg::NOTE_W-1:0]  note_number_o,
  output logic [kvt_pkg::VEL_W-1:0]   note_velocity_o,
  output logic [kvt_pkg::KEY_W-1:0]   event_key_o
);
  import kvt_pkg::*;

  kvt_cfg_t  cfg_q;
  kvt_item_t item;
  logic      item_valid;
  logic      pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.th_low     <= TH_LOW_RESET;
      cfg_q.th_high    <= TH_HIGH_RESET;
      cfg_q.th_release <= TH_RELEASE_RESET;
      cfg_q.base_note  <= BASE_NOTE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_TH_LOW:     cfg_q.th_low     <= cfg_wdata_i;
        REG_TH_HIGH:    cfg_q.th_high    <= cfg_wdata_i;
        REG_TH_RELEASE: cfg_q.th_release <= cfg_wdata_i;
        REG_BASE_NOTE:  cfg_q.base_note  <= cfg_wdata_i[NOTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  kvt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .key_number_i   (key_number_i),
    .sample_value_i (sample_value_i),
    .time_us_i      (time_us_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .pop_i          (pop)
  );

  kvt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .note_number_o   (note_number_o),
    .note_velocity_o (note_velocity_o),
    .event_key_o     (event_key_o)
  );

endmodule
